// File: src/kf2_pkg.sv
// Shared types, constants, microprogram and saturation helpers of the two-state Kalman filter.
package kf2_pkg;

  localparam int PORT_W          = 32;
  localparam int DEF_DATA_WIDTH  = 32;
  localparam int DEF_FRAC_BITS   = 16;
  localparam int WIDE_W          = 66;
  localparam int PC_W            = 7;

  typedef logic signed [PORT_W-1:0] word_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic [PC_W-1:0]          pc_t;

  typedef enum logic [2:0] {
    OP_MUL,
    OP_ADD,
    OP_SUB,
    OP_DIV,
    OP_BR,
    OP_END
  } op_t;

  typedef enum logic [5:0] {
    SEL_ZERO, SEL_ONE,
    SEL_X0, SEL_X1,
    SEL_P00, SEL_P01, SEL_P10, SEL_P11,
    SEL_Z, SEL_U0, SEL_U1,
    SEL_H0, SEL_H1, SEL_RN,
    SEL_F00, SEL_F01, SEL_F10, SEL_F11,
    SEL_Y, SEL_PH0, SEL_PH1, SEL_S, SEL_K0, SEL_K1,
    SEL_A0, SEL_A1, SEL_A2, SEL_A3,
    SEL_T0, SEL_T1, SEL_T2, SEL_T3,
    SEL_M0, SEL_M1
  } sel_t;

  typedef enum logic [2:0] {
    CFG_TRANS_00,
    CFG_TRANS_01,
    CFG_TRANS_10,
    CFG_TRANS_11,
    CFG_OBS_0,
    CFG_OBS_1,
    CFG_MEAS_NOISE
  } cfg_idx_t;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_SKIP = 2'd1;
  localparam logic [1:0] STAT_SAT  = 2'd2;

  typedef struct packed {
    op_t  op;
    sel_t a;
    sel_t b;
    sel_t c;
    sel_t d;
  } step_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_DONE
  } ctl_state_t;

  typedef struct packed {
    logic  accept;
    logic  exec;
    logic  div_start;
    logic  publish;
    step_t step;
  } dp_cmd_t;

  typedef struct packed {
    logic s_le0;
    logic div_done;
  } dp_stat_t;

  // First step of the prediction phase; the update is skipped by jumping here.
  localparam pc_t PC_PREDICT = pc_t'(44);

  function automatic step_t st(op_t op, sel_t a, sel_t b, sel_t c, sel_t d);
    step_t s;
    s.op = op;
    s.a  = a;
    s.b  = b;
    s.c  = c;
    s.d  = d;
    return s;
  endfunction

  function automatic step_t prog_step(pc_t pc);
    step_t s;
    case (pc)
      // Innovation y = z - Hx.
      7'd0:  s = st(OP_MUL, SEL_H0,  SEL_X0,  SEL_ZERO, SEL_M0);
      7'd1:  s = st(OP_MUL, SEL_H1,  SEL_X1,  SEL_ZERO, SEL_M1);
      7'd2:  s = st(OP_ADD, SEL_M0,  SEL_M1,  SEL_ZERO, SEL_T0);
      7'd3:  s = st(OP_SUB, SEL_Z,   SEL_T0,  SEL_ZERO, SEL_Y);
      // PH' and S = HPH' + R.
      7'd4:  s = st(OP_MUL, SEL_P00, SEL_H0,  SEL_ZERO, SEL_M0);
      7'd5:  s = st(OP_MUL, SEL_P01, SEL_H1,  SEL_ZERO, SEL_M1);
      7'd6:  s = st(OP_ADD, SEL_M0,  SEL_M1,  SEL_ZERO, SEL_PH0);
      7'd7:  s = st(OP_MUL, SEL_P10, SEL_H0,  SEL_ZERO, SEL_M0);
      7'd8:  s = st(OP_MUL, SEL_P11, SEL_H1,  SEL_ZERO, SEL_M1);
      7'd9:  s = st(OP_ADD, SEL_M0,  SEL_M1,  SEL_ZERO, SEL_PH1);
      7'd10: s = st(OP_MUL, SEL_H0,  SEL_PH0, SEL_ZERO, SEL_M0);
      7'd11: s = st(OP_MUL, SEL_H1,  SEL_PH1, SEL_ZERO, SEL_M1);
      7'd12: s = st(OP_ADD, SEL_M0,  SEL_M1,  SEL_RN,   SEL_S);
      7'd13: s = st(OP_BR,  SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO);
      // Gain and state update.
      7'd14: s = st(OP_DIV, SEL_PH0, SEL_S,   SEL_ZERO, SEL_K0);
      7'd15: s = st(OP_DIV, SEL_PH1, SEL_S,   SEL_ZERO, SEL_K1);
      7'd16: s = st(OP_MUL, SEL_K0,  SEL_Y,   SEL_ZERO, SEL_M0);
      7'd17: s = st(OP_ADD, SEL_X0,  SEL_M0,  SEL_ZERO, SEL_X0);
      7'd18: s = st(OP_MUL, SEL_K1,  SEL_Y,   SEL_ZERO, SEL_M0);
      7'd19: s = st(OP_ADD, SEL_X1,  SEL_M0,  SEL_ZERO, SEL_X1);
      // A = I - KH.
      7'd20: s = st(OP_MUL, SEL_K0,  SEL_H0,  SEL_ZERO, SEL_M0);
      7'd21: s = st(OP_SUB, SEL_ONE, SEL_M0,  SEL_ZERO, SEL_A0);
      7'd22: s = st(OP_MUL, SEL_K0,  SEL_H1,  SEL_ZERO, SEL_M0);
      7'd23: s = st(OP_SUB, SEL_ZERO, SEL_M0, SEL_ZERO, SEL_A1);
      7'd24: s = st(OP_MUL, SEL_K1,  SEL_H0,  SEL_ZERO, SEL_M0);
      7'd25: s = st(OP_SUB, SEL_ZERO, SEL_M0, SEL_ZERO, SEL_A2);
      7'd26: s = st(OP_MUL, SEL_K1,  SEL_H1,  SEL_ZERO, SEL_M0);
      7'd27: s = st(OP_SUB, SEL_ONE, SEL_M0,  SEL_ZERO, SEL_A3);
      // T = A * P, then P = T.
      7'd28: s = st(OP_MUL, SEL_A0,  SEL_P00, SEL_ZERO, SEL_M0);
      7'd29: s = st(OP_MUL, SEL_A1,  SEL_P10, SEL_ZERO, SEL_M1);
      7'd30: s = st(OP_ADD, SEL_M0,  SEL_M1,  SEL_ZERO, SEL_T0);
      7'd31: s = st(OP_MUL, SEL_A0,  SEL_P01, SEL_ZERO, SEL_M0);
      7'd32: s = st(OP_MUL, SEL_A1,  SEL_P11, SEL_ZERO, SEL_M1);
      7'd33: s = st(OP_ADD, SEL_M0,  SEL_M1,  SEL_ZERO, SEL_T1);
      7'd34: s = st(OP_MUL, SEL_A2,  SEL_P00, SEL_ZERO, SEL_M0);
      7'd35: s = st(OP_MUL, SEL_A3,  SEL_P10, SEL_ZERO, SEL_M1);
      7'd36: s = st(OP_ADD, SEL_M0,  SEL_M1,  SEL_ZERO, SEL_T2);
      7'd37: s = st(OP_MUL, SEL_A2,  SEL_P01, SEL_ZERO, SEL_M0);
      7'd38: s = st(OP_MUL, SEL_A3,  SEL_P11, SEL_ZERO, SEL_M1);
      7'd39: s = st(OP_ADD, SEL_M0,  SEL_M1,  SEL_ZERO, SEL_T3);
      7'd40: s = st(OP_ADD, SEL_T0,  SEL_ZERO, SEL_ZERO, SEL_P00);
      7'd41: s = st(OP_ADD, SEL_T1,  SEL_ZERO, SEL_ZERO, SEL_P01);
      7'd42: s = st(OP_ADD, SEL_T2,  SEL_ZERO, SEL_ZERO, SEL_P10);
      7'd43: s = st(OP_ADD, SEL_T3,  SEL_ZERO, SEL_ZERO, SEL_P11);
      // Prediction of the state: x = Fx + u.
      7'd44: s = st(OP_MUL, SEL_F00, SEL_X0,  SEL_ZERO, SEL_M0);
      7'd45: s = st(OP_MUL, SEL_F01, SEL_X1,  SEL_ZERO, SEL_M1);
      7'd46: s = st(OP_ADD, SEL_M0,  SEL_M1,  SEL_ZERO, SEL_T0);
      7'd47: s = st(OP_ADD, SEL_T0,  SEL_U0,  SEL_ZERO, SEL_T0);
      7'd48: s = st(OP_MUL, SEL_F10, SEL_X0,  SEL_ZERO, SEL_M0);
      7'd49: s = st(OP_MUL, SEL_F11, SEL_X1,  SEL_ZERO, SEL_M1);
      7'd50: s = st(OP_ADD, SEL_M0,  SEL_M1,  SEL_ZERO, SEL_T1);
      7'd51: s = st(OP_ADD, SEL_T1,  SEL_U1,  SEL_ZERO, SEL_T1);
      7'd52: s = st(OP_ADD, SEL_T0,  SEL_ZERO, SEL_ZERO, SEL_X0);
      7'd53: s = st(OP_ADD, SEL_T1,  SEL_ZERO, SEL_ZERO, SEL_X1);
      // T = F * P.
      7'd54: s = st(OP_MUL, SEL_F00, SEL_P00, SEL_ZERO, SEL_M0);
      7'd55: s = st(OP_MUL, SEL_F01, SEL_P10, SEL_ZERO, SEL_M1);
      7'd56: s = st(OP_ADD, SEL_M0,  SEL_M1,  SEL_ZERO, SEL_T0);
      7'd57: s = st(OP_MUL, SEL_F00, SEL_P01, SEL_ZERO, SEL_M0);
      7'd58: s = st(OP_MUL, SEL_F01, SEL_P11, SEL_ZERO, SEL_M1);
      7'd59: s = st(OP_ADD, SEL_M0,  SEL_M1,  SEL_ZERO, SEL_T1);
      7'd60: s = st(OP_MUL, SEL_F10, SEL_P00, SEL_ZERO, SEL_M0);
      7'd61: s = st(OP_MUL, SEL_F11, SEL_P10, SEL_ZERO, SEL_M1);
      7'd62: s = st(OP_ADD, SEL_M0,  SEL_M1,  SEL_ZERO, SEL_T2);
      7'd63: s = st(OP_MUL, SEL_F10, SEL_P01, SEL_ZERO, SEL_M0);
      7'd64: s = st(OP_MUL, SEL_F11, SEL_P11, SEL_ZERO, SEL_M1);
      7'd65: s = st(OP_ADD, SEL_M0,  SEL_M1,  SEL_ZERO, SEL_T3);
      // P = T * F'.
      7'd66: s = st(OP_MUL, SEL_T0,  SEL_F00, SEL_ZERO, SEL_M0);
      7'd67: s = st(OP_MUL, SEL_T1,  SEL_F01, SEL_ZERO, SEL_M1);
      7'd68: s = st(OP_ADD, SEL_M0,  SEL_M1,  SEL_ZERO, SEL_P00);
      7'd69: s = st(OP_MUL, SEL_T0,  SEL_F10, SEL_ZERO, SEL_M0);
      7'd70: s = st(OP_MUL, SEL_T1,  SEL_F11, SEL_ZERO, SEL_M1);
      7'd71: s = st(OP_ADD, SEL_M0,  SEL_M1,  SEL_ZERO, SEL_P01);
      7'd72: s = st(OP_MUL, SEL_T2,  SEL_F00, SEL_ZERO, SEL_M0);
      7'd73: s = st(OP_MUL, SEL_T3,  SEL_F01, SEL_ZERO, SEL_M1);
      7'd74: s = st(OP_ADD, SEL_M0,  SEL_M1,  SEL_ZERO, SEL_P10);
      7'd75: s = st(OP_MUL, SEL_T2,  SEL_F10, SEL_ZERO, SEL_M0);
      7'd76: s = st(OP_MUL, SEL_T3,  SEL_F11, SEL_ZERO, SEL_M1);
      7'd77: s = st(OP_ADD, SEL_M0,  SEL_M1,  SEL_ZERO, SEL_P11);
      default: s = st(OP_END, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO);
    endcase
    return s;
  endfunction

  // Saturate a wide value to the signed range of w bits.
  function automatic word_t clip_w(wide_t v, int w);
    wide_t vmax;
    wide_t vmin;
    vmax = (wide_t'(1) <<< (w - 1)) - wide_t'(1);
    vmin = -vmax - wide_t'(1);
    if (v > vmax) return word_t'(vmax);
    if (v < vmin) return word_t'(vmin);
    return word_t'(v);
  endfunction

  function automatic logic clip_hit(wide_t v, int w);
    wide_t vmax;
    wide_t vmin;
    vmax = (wide_t'(1) <<< (w - 1)) - wide_t'(1);
    vmin = -vmax - wide_t'(1);
    return (v > vmax) || (v < vmin);
  endfunction

endpackage

// File: src/kf2_in_if.sv
// Input channel of the Kalman filter: handshake and one item's fields.
interface kf2_in_if
  import kf2_pkg::*;
;
  logic  valid;
  logic  ready;
  logic  mode;
  word_t meas;
  word_t ctrl_0;
  word_t ctrl_1;
  word_t init_s0;
  word_t init_s1;
  word_t init_c00;
  word_t init_c01;
  word_t init_c10;
  word_t init_c11;

  modport source (
    output valid, mode, meas, ctrl_0, ctrl_1, init_s0, init_s1,
           init_c00, init_c01, init_c10, init_c11,
    input  ready
  );
  modport sink (
    input  valid, mode, meas, ctrl_0, ctrl_1, init_s0, init_s1,
           init_c00, init_c01, init_c10, init_c11,
    output ready
  );
endinterface

// File: src/kf2_out_if.sv
// Result channel of the Kalman filter: handshake and one result's fields.
interface kf2_out_if
  import kf2_pkg::*;
;
  logic       valid;
  logic       ready;
  word_t      est_0;
  word_t      est_1;
  word_t      cov_00;
  word_t      cov_01;
  word_t      cov_10;
  word_t      cov_11;
  logic [1:0] status;

  modport source (
    output valid, est_0, est_1, cov_00, cov_01, cov_10, cov_11, status,
    input  ready
  );
  modport sink (
    input  valid, est_0, est_1, cov_00, cov_01, cov_10, cov_11, status,
    output ready
  );
endinterface

// File: src/kf2_div.sv
// Restoring divider for the gain: one quotient bit per cycle, magnitude and sign out.
module kf2_div
  import kf2_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  word_t                         num,
  input  word_t                         den,
  output logic                          done,
  output logic                          neg,
  output logic [PORT_W+FRAC_BITS-1:0]   quo
);

  localparam int NUMW  = PORT_W + FRAC_BITS;
  localparam int CNT_W = $clog2(NUMW);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [NUMW-1:0]     num_r, num_nxt;
  logic [NUMW-1:0]     quo_r, quo_nxt;
  logic [PORT_W:0]     rem_r, rem_nxt;
  logic [PORT_W-1:0]   div_r, div_nxt;
  logic                neg_r, neg_nxt;
  logic [PORT_W-1:0]   num_abs;
  logic [PORT_W:0]     rem_sh;
  logic                fits;

  assign num_abs = num[PORT_W-1] ? (~num + 1'b1) : num;
  assign rem_sh  = {rem_r[PORT_W-1:0], num_r[NUMW-1]};
  assign fits    = rem_sh >= {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = {num_abs, {FRAC_BITS{1'b0}}};
      quo_nxt  = '0;
      rem_nxt  = '0;
      div_nxt  = den;
      neg_nxt  = num[PORT_W-1];
    end else if (busy_r) begin
      rem_nxt = fits ? (rem_sh - {1'b0, div_r}) : rem_sh;
      quo_nxt = {quo_r[NUMW-2:0], fits};
      num_nxt = {num_r[NUMW-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NUMW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    neg_r <= neg_nxt;
  end

  assign done = done_r;
  assign neg  = neg_r;
  assign quo  = quo_r;

endmodule

// File: src/kf2_datapath.sv
// Datapath: configuration, state and scratch registers, shared multiplier, adder and divider.
module kf2_datapath
  import kf2_pkg::*;
#(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [2:0] cfg_idx,
  input  word_t      cfg_wdata,
  input  logic       in_mode,
  input  word_t      in_meas,
  input  word_t      in_ctrl_0,
  input  word_t      in_ctrl_1,
  input  word_t      in_init_s0,
  input  word_t      in_init_s1,
  input  word_t      in_init_c00,
  input  word_t      in_init_c01,
  input  word_t      in_init_c10,
  input  word_t      in_init_c11,
  input  dp_cmd_t    cmd,
  output dp_stat_t   stat,
  output word_t      est_0,
  output word_t      est_1,
  output word_t      cov_00,
  output word_t      cov_01,
  output word_t      cov_10,
  output word_t      cov_11,
  output logic [1:0] status
);

  localparam int    EFF_W = (DATA_WIDTH > PORT_W) ? PORT_W : DATA_WIDTH;
  localparam int    NUMW  = PORT_W + FRAC_BITS;
  localparam word_t ONE   = word_t'(64'sd1 <<< FRAC_BITS);
  localparam wide_t HALF  = wide_t'(1) <<< (FRAC_BITS - 1);

  word_t trans_00_r, trans_01_r, trans_10_r, trans_11_r, obs_0_r, obs_1_r;
  logic [PORT_W-2:0] meas_noise_r;

  word_t x0_r, x1_r, p00_r, p01_r, p10_r, p11_r;
  word_t z_r, u0_r, u1_r;
  word_t y_r, ph0_r, ph1_r, s_r, k0_r, k1_r;
  word_t a0_r, a1_r, a2_r, a3_r, t0_r, t1_r, t2_r, t3_r, m0_r, m1_r;
  logic  sat_r, skip_r;

  word_t est_0_r, est_1_r, cov_00_r, cov_01_r, cov_10_r, cov_11_r;
  logic [1:0] status_r;

  word_t              opa, opb, opc;
  logic signed [63:0] prod;
  wide_t              mul_wide, add_wide, sub_wide, div_wide, res_wide;
  logic               wr_en;
  word_t              wr_val;
  logic               div_done, div_neg;
  logic [NUMW-1:0]    div_quo;

  function automatic word_t qclip(word_t v);
    return clip_w(wide_t'(v), EFF_W);
  endfunction

  function automatic word_t rd(sel_t s);
    word_t v;
    case (s)
      SEL_ZERO: v = '0;
      SEL_ONE:  v = ONE;
      SEL_X0:   v = x0_r;
      SEL_X1:   v = x1_r;
      SEL_P00:  v = p00_r;
      SEL_P01:  v = p01_r;
      SEL_P10:  v = p10_r;
      SEL_P11:  v = p11_r;
      SEL_Z:    v = z_r;
      SEL_U0:   v = u0_r;
      SEL_U1:   v = u1_r;
      SEL_H0:   v = qclip(obs_0_r);
      SEL_H1:   v = qclip(obs_1_r);
      SEL_RN:   v = {1'b0, meas_noise_r};
      SEL_F00:  v = qclip(trans_00_r);
      SEL_F01:  v = qclip(trans_01_r);
      SEL_F10:  v = qclip(trans_10_r);
      SEL_F11:  v = qclip(trans_11_r);
      SEL_Y:    v = y_r;
      SEL_PH0:  v = ph0_r;
      SEL_PH1:  v = ph1_r;
      SEL_S:    v = s_r;
      SEL_K0:   v = k0_r;
      SEL_K1:   v = k1_r;
      SEL_A0:   v = a0_r;
      SEL_A1:   v = a1_r;
      SEL_A2:   v = a2_r;
      SEL_A3:   v = a3_r;
      SEL_T0:   v = t0_r;
      SEL_T1:   v = t1_r;
      SEL_T2:   v = t2_r;
      SEL_T3:   v = t3_r;
      SEL_M0:   v = m0_r;
      SEL_M1:   v = m1_r;
      default:  v = '0;
    endcase
    return v;
  endfunction

  assign opa = rd(cmd.step.a);
  assign opb = rd(cmd.step.b);
  assign opc = rd(cmd.step.c);

  // Product rounds half up: add half an LSB, then floor shift.
  assign prod     = opa * opb;
  assign mul_wide = (wide_t'(prod) + HALF) >>> FRAC_BITS;
  assign add_wide = wide_t'(opa) + wide_t'(opb) + wide_t'(opc);
  assign sub_wide = wide_t'(opa) - wide_t'(opb);
  assign div_wide = div_neg ? -wide_t'({1'b0, div_quo}) : wide_t'({1'b0, div_quo});

  always_comb begin
    wr_en    = 1'b0;
    res_wide = '0;
    if (div_done) begin
      wr_en    = 1'b1;
      res_wide = div_wide;
    end else if (cmd.exec) begin
      case (cmd.step.op)
        OP_MUL: begin
          wr_en    = 1'b1;
          res_wide = mul_wide;
        end
        OP_ADD: begin
          wr_en    = 1'b1;
          res_wide = add_wide;
        end
        OP_SUB: begin
          wr_en    = 1'b1;
          res_wide = sub_wide;
        end
        default: wr_en = 1'b0;
      endcase
    end
  end
  assign wr_val = clip_w(res_wide, EFF_W);

  kf2_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.div_start),
    .num  (opa),
    .den  (opb),
    .done (div_done),
    .neg  (div_neg),
    .quo  (div_quo)
  );

  assign stat.s_le0    = (s_r <= 0);
  assign stat.div_done = div_done;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trans_00_r   <= ONE;
      trans_01_r   <= ONE;
      trans_10_r   <= '0;
      trans_11_r   <= ONE;
      obs_0_r      <= ONE;
      obs_1_r      <= '0;
      meas_noise_r <= ONE[PORT_W-2:0];
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_TRANS_00:   trans_00_r   <= cfg_wdata;
        CFG_TRANS_01:   trans_01_r   <= cfg_wdata;
        CFG_TRANS_10:   trans_10_r   <= cfg_wdata;
        CFG_TRANS_11:   trans_11_r   <= cfg_wdata;
        CFG_OBS_0:      obs_0_r      <= cfg_wdata;
        CFG_OBS_1:      obs_1_r      <= cfg_wdata;
        CFG_MEAS_NOISE: meas_noise_r <= cfg_wdata[PORT_W-2:0];
        default: ;
      endcase
    end
  end

  // Filter state, flags and loading of an item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x0_r   <= '0;
      x1_r   <= '0;
      p00_r  <= '0;
      p01_r  <= '0;
      p10_r  <= '0;
      p11_r  <= '0;
      sat_r  <= 1'b0;
      skip_r <= 1'b0;
    end else if (cmd.accept) begin
      sat_r  <= 1'b0;
      skip_r <= 1'b0;
      if (in_mode) begin
        x0_r  <= qclip(in_init_s0);
        x1_r  <= qclip(in_init_s1);
        p00_r <= qclip(in_init_c00);
        p01_r <= qclip(in_init_c01);
        p10_r <= qclip(in_init_c10);
        p11_r <= qclip(in_init_c11);
      end
    end else begin
      if (wr_en && clip_hit(res_wide, EFF_W)) sat_r <= 1'b1;
      if (cmd.exec && cmd.step.op == OP_BR) skip_r <= stat.s_le0;
      if (wr_en) begin
        case (cmd.step.d)
          SEL_X0:  x0_r  <= wr_val;
          SEL_X1:  x1_r  <= wr_val;
          SEL_P00: p00_r <= wr_val;
          SEL_P01: p01_r <= wr_val;
          SEL_P10: p10_r <= wr_val;
          SEL_P11: p11_r <= wr_val;
          default: ;
        endcase
      end
    end
  end

  // Scratch registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      z_r  <= in_meas;
      u0_r <= in_ctrl_0;
      u1_r <= in_ctrl_1;
    end
    if (wr_en) begin
      case (cmd.step.d)
        SEL_Y:   y_r   <= wr_val;
        SEL_PH0: ph0_r <= wr_val;
        SEL_PH1: ph1_r <= wr_val;
        SEL_S:   s_r   <= wr_val;
        SEL_K0:  k0_r  <= wr_val;
        SEL_K1:  k1_r  <= wr_val;
        SEL_A0:  a0_r  <= wr_val;
        SEL_A1:  a1_r  <= wr_val;
        SEL_A2:  a2_r  <= wr_val;
        SEL_A3:  a3_r  <= wr_val;
        SEL_T0:  t0_r  <= wr_val;
        SEL_T1:  t1_r  <= wr_val;
        SEL_T2:  t2_r  <= wr_val;
        SEL_T3:  t3_r  <= wr_val;
        SEL_M0:  m0_r  <= wr_val;
        SEL_M1:  m1_r  <= wr_val;
        default: ;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      est_0_r  <= x0_r;
      est_1_r  <= x1_r;
      cov_00_r <= p00_r;
      cov_01_r <= p01_r;
      cov_10_r <= p10_r;
      cov_11_r <= p11_r;
      status_r <= skip_r ? STAT_SKIP : (sat_r ? STAT_SAT : STAT_OK);
    end
  end

  assign est_0  = est_0_r;
  assign est_1  = est_1_r;
  assign cov_00 = cov_00_r;
  assign cov_01 = cov_01_r;
  assign cov_10 = cov_10_r;
  assign cov_11 = cov_11_r;
  assign status = status_r;

endmodule

// File: src/kf2_ctrl.sv
// Controller: sequences the microprogram, waits on the divider and runs the handshakes.
module kf2_ctrl
  import kf2_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_mode,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  ctl_state_t state_r, state_nxt;
  pc_t        pc_r, pc_nxt;
  logic       out_valid_r, out_valid_nxt;
  step_t      step;
  logic       accept;
  logic       slot_free;

  assign step      = prog_step(pc_r);
  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          pc_nxt    = '0;
          state_nxt = in_mode ? ST_DONE : ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (step.op)
          OP_DIV:  state_nxt = ST_DIV;
          OP_BR:   pc_nxt    = stat.s_le0 ? PC_PREDICT : pc_r + 1'b1;
          OP_END:  state_nxt = ST_DONE;
          default: pc_nxt    = pc_r + 1'b1;
        endcase
      end
      ST_DIV: begin
        if (stat.div_done) begin
          pc_nxt    = pc_r + 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_DONE: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd           = '0;
    cmd.step      = step;
    cmd.accept    = accept;
    cmd.exec      = (state_r == ST_EXEC);
    cmd.div_start = (state_r == ST_EXEC) && (step.op == OP_DIV);
    cmd.publish   = (state_r == ST_DONE) && slot_free;
    out_valid_nxt = out_valid_r;
    if (cmd.publish) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: src/kalman_filter_two_state.sv
// Top level of the two-state Kalman filter with a scalar measurement.
//
// This block runs a two-state Kalman filter in signed fixed point (Q16.16 by
// default) with one scalar measurement per beat. A load beat (mode 1) sets the
// state vector and the 2x2 covariance and returns them; a measure beat (mode 0)
// runs the update (innovation, innovation variance S, gain, state and
// covariance correction) and then the prediction through the transition matrix,
// and returns the new state, covariance and a status code. Every product rounds
// half up and every intermediate value saturates; status 2 reports that some
// value clipped, and status 1 reports that S was not positive, so the update was
// skipped and only the prediction ran. A load beat goes from acceptance straight
// to the done state, and its result is published once the output register is
// free. A measure beat is set by a microprogram of 78 steps on one shared
// multiplier and adder, one step per cycle while no division runs, plus two gain
// divisions in a restoring divider that produces one quotient bit per cycle.
// One beat is in flight at a time; the result sits in an output register, so
// the next beat is accepted while it waits to be taken.
// Configuration registers are written through the cfg port and should only be
// changed while no beat is in progress.
module kalman_filter_two_state
  import kf2_pkg::*;
#(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_idx,
  input  word_t        cfg_wdata,
  kf2_in_if.sink       in_ch,
  kf2_out_if.source    out_ch
);

  // Commands from the controller and status back from the datapath.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  kf2_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_mode  (in_ch.mode),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  kf2_datapath #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .in_mode    (in_ch.mode),
    .in_meas    (in_ch.meas),
    .in_ctrl_0  (in_ch.ctrl_0),
    .in_ctrl_1  (in_ch.ctrl_1),
    .in_init_s0 (in_ch.init_s0),
    .in_init_s1 (in_ch.init_s1),
    .in_init_c00(in_ch.init_c00),
    .in_init_c01(in_ch.init_c01),
    .in_init_c10(in_ch.init_c10),
    .in_init_c11(in_ch.init_c11),
    .cmd        (cmd),
    .stat       (stat),
    .est_0      (out_ch.est_0),
    .est_1      (out_ch.est_1),
    .cov_00     (out_ch.cov_00),
    .cov_01     (out_ch.cov_01),
    .cov_10     (out_ch.cov_10),
    .cov_11     (out_ch.cov_11),
    .status     (out_ch.status)
  );

endmodule
